[design/cfs_pkg.sv]
package cfs_pkg;

  // checkpoint space
  localparam int NUM_POINTS = 8;
  localparam int PT_W = 3;
  localparam int ADJ_W = 64;
  localparam int CNT_W = 16;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_ADJACENCY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_RESET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_THR = 3'd4;

  // event kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  // supervision status
  localparam logic [1:0] ST_DEACT = 2'd0;
  localparam logic [1:0] ST_OK = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  typedef struct packed {
    logic [ADJ_W-1:0] adjacency_bits;
    logic [PT_W-1:0]  initial_checkpoint;
    logic             allow_reset;
    logic [CNT_W-1:0] pass_threshold;
    logic [CNT_W-1:0] fail_threshold;
  } cfs_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [PT_W-1:0] checkpoint;
  } cfs_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       status_changed;
    logic       report_passed;
    logic       report_handled;
  } cfs_result_t;

endpackage

[design/cfs_cfg_regs.sv]
module cfs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output cfs_pkg::cfs_cfg_t              cfg
);
  import cfs_pkg::*;

  cfs_cfg_t cfg_r;
  cfs_cfg_t cfg_nxt;

  // register decode, writes past the last register are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ADJACENCY:   cfg_nxt.adjacency_bits = cfg_wdata[ADJ_W-1:0];
        REG_INITIAL:     cfg_nxt.initial_checkpoint = cfg_wdata[PT_W-1:0];
        REG_ALLOW_RESET: cfg_nxt.allow_reset = cfg_wdata[0];
        REG_PASS_THR:    cfg_nxt.pass_threshold = cfg_wdata[CNT_W-1:0];
        REG_FAIL_THR:    cfg_nxt.fail_threshold = cfg_wdata[CNT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adjacency_bits <= '0;
      cfg_r.initial_checkpoint <= '0;
      cfg_r.allow_reset <= 1'b0;
      cfg_r.pass_threshold <= CNT_W'(1);
      cfg_r.fail_threshold <= CNT_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/cfs_engine.sv]
module cfs_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfs_pkg::cfs_cfg_t     cfg,
  input  cfs_pkg::cfs_item_t    item,
  input  logic                  step,
  output cfs_pkg::cfs_result_t  result
);
  import cfs_pkg::*;

  logic [PT_W-1:0]  cur_point_r, cur_point_nxt;
  logic             seen_first_r, seen_first_nxt;
  logic [CNT_W-1:0] pass_cnt_r, pass_cnt_nxt;
  logic [CNT_W-1:0] fail_cnt_r, fail_cnt_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             edge_ok;
  logic             passed;
  logic [CNT_W-1:0] pass_inc;
  logic [CNT_W-1:0] fail_inc;
  logic [1:0]       report_status;

  // adjacency lookup, bit from*8+to
  always_comb begin
    edge_ok = 1'b0;
    if (int'(cur_point_r) < NUM_POINTS && int'(item.checkpoint) < NUM_POINTS) begin
      edge_ok = cfg.adjacency_bits[{cur_point_r, item.checkpoint}];
    end
  end

  // report verdict
  always_comb begin
    if (!seen_first_r) begin
      passed = (item.checkpoint == cfg.initial_checkpoint);
    end else if (cfg.allow_reset && item.checkpoint == cfg.initial_checkpoint) begin
      passed = 1'b1;
    end else begin
      passed = edge_ok;
    end
  end

  // saturating counters
  assign pass_inc = (pass_cnt_r == '1) ? pass_cnt_r : pass_cnt_r + CNT_W'(1);
  assign fail_inc = (fail_cnt_r == '1) ? fail_cnt_r : fail_cnt_r + CNT_W'(1);

  // status after a report
  always_comb begin
    if (passed) begin
      report_status = (pass_inc >= cfg.pass_threshold) ? ST_OK : status_r;
    end else begin
      report_status = (fail_inc >= cfg.fail_threshold) ? ST_EXPIRED : ST_FAILED;
    end
  end

  // event decode and next state
  always_comb begin
    cur_point_nxt = cur_point_r;
    seen_first_nxt = seen_first_r;
    pass_cnt_nxt = pass_cnt_r;
    fail_cnt_nxt = fail_cnt_r;
    status_nxt = status_r;
    result = '0;
    unique case (item.kind)
      KIND_START: begin
        cur_point_nxt = cfg.initial_checkpoint;
        seen_first_nxt = 1'b0;
        pass_cnt_nxt = '0;
        fail_cnt_nxt = '0;
        status_nxt = ST_OK;
      end
      KIND_STOP: begin
        status_nxt = ST_DEACT;
        result.status_changed = (status_r != ST_DEACT);
      end
      KIND_REPORT: begin
        if (status_r != ST_DEACT) begin
          result.report_handled = 1'b1;
          result.report_passed = passed;
          seen_first_nxt = 1'b1;
          cur_point_nxt = item.checkpoint;
          pass_cnt_nxt = passed ? pass_inc : '0;
          fail_cnt_nxt = passed ? '0 : fail_inc;
          status_nxt = report_status;
          result.status_changed = (report_status != status_r);
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
    result.status = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_point_r <= '0;
      seen_first_r <= 1'b0;
      pass_cnt_r <= '0;
      fail_cnt_r <= '0;
      status_r <= ST_DEACT;
    end else if (step) begin
      cur_point_r <= cur_point_nxt;
      seen_first_r <= seen_first_nxt;
      pass_cnt_r <= pass_cnt_nxt;
      fail_cnt_r <= fail_cnt_nxt;
      status_r <= status_nxt;
    end
  end

  // a consecutive run never has both counters running
  a_cnt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pass_cnt_r != '0 && fail_cnt_r != '0))
    else $error("pass and fail counts both nonzero");

  // deactivated status leaves counters and point untouched on a report
  a_deact_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && status_r == ST_DEACT && item.kind == KIND_REPORT
    |=> $stable(pass_cnt_r) && $stable(fail_cnt_r) && $stable(cur_point_r))
    else $error("report while deactivated changed state");

  // a start always lands in ok with cleared counters
  a_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.kind == KIND_START
    |=> status_r == ST_OK && pass_cnt_r == '0 && !seen_first_r)
    else $error("start did not restore supervision");

endmodule

[design/checkpoint_flow_supervisor_core.sv]
// checkpoint flow supervisor
//
// Events come in on the in_ channel (in_kind: report, start, stop; in_checkpoint
// for reports). Each accepted word produces exactly one result word on the out_
// channel: status after the event, a status-change flag, and pass/handled flags
// for checkpoint reports.
// The cfg_ port writes the adjacency bitmap, initial checkpoint, allow-reset bit and
// pass/fail thresholds; the user writes it only while no event is in flight, which
// the block does not enforce. An accepted word sits in an input register until the
// result register can take it; it is then evaluated against the supervision state
// and loaded into the result register, where the receiver takes it.
// One word per cycle is sustained while out_stall is low, since the bitmap lookup
// and counter update are combinational.
// When out_stall is held, the result register keeps its word and the input
// register holds one more; in_stall rises only once both are full.
// Synchronous reset (rst_n low) empties both registers, deactivates supervision,
// clears counters and returns configuration to its defaults.
module checkpoint_flow_supervisor_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic [cfs_pkg::PT_W-1:0]       in_checkpoint,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic                           out_status_changed,
  output logic                           out_report_passed,
  output logic                           out_report_handled,
  input  logic                           cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cfs_pkg::*;

  cfs_cfg_t    cfg;
  cfs_result_t eval_res;

  logic        s1_valid_r, s1_valid_nxt;
  cfs_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  cfs_result_t out_res_r;
  logic        out_load;
  logic        s1_adv;
  logic        in_take;

  // configuration registers
  cfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // supervision state and evaluation
  cfs_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (s1_item_r),
    .step   (s1_adv),
    .result (eval_res)
  );

  // pipeline flow control
  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind <= in_kind;
      s1_item_r.checkpoint <= in_checkpoint;
    end
    if (s1_adv) begin
      out_res_r <= eval_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_res_r.status;
  assign out_status_changed = out_res_r.status_changed;
  assign out_report_passed = out_res_r.report_passed;
  assign out_report_handled = out_res_r.report_handled;

  // a pass is only flagged on a handled report
  a_pass_handled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.report_passed && !out_res_r.report_handled))
    else $error("pass flagged on unhandled word");

  // a failed report leaves status failed or expired
  a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.report_handled && !out_res_r.report_passed
    |-> out_res_r.status == ST_FAILED || out_res_r.status == ST_EXPIRED)
    else $error("failed report with wrong status");

  // input stalls only with the input register occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room left");

endmodule

[bench/checkpoint_flow_supervisor_core_test.sv]
module checkpoint_flow_supervisor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  // kind code the block leaves unused
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int MAX_PRINTED = 40;
  localparam int HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_kind = KIND_REPORT;
  logic [PT_W-1:0]       in_checkpoint = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic                  out_status_changed;
  logic                  out_report_passed;
  logic                  out_report_handled;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ADJACENCY;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the supervision state and its settings
  cfs_cfg_t        flow_cfg;
  logic [PT_W-1:0] sv_point;
  logic            sv_seen;
  logic [CNT_W-1:0] sv_passes;
  logic [CNT_W-1:0] sv_fails;
  logic [1:0]      sv_status;

  cfs_result_t pending_verdicts[$];
  int error_count = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  checkpoint_flow_supervisor_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_checkpoint      (in_checkpoint),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_status_changed (out_status_changed),
    .out_report_passed  (out_report_passed),
    .out_report_handled (out_report_handled),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // expected outcome of one event word, advances the shadow state
  function automatic cfs_result_t supervise_event(input logic [1:0] kind,
                                                  input logic [PT_W-1:0] cp);
    cfs_result_t res;
    logic ok;
    logic [1:0] new_status;
    res = '0;
    ok = 1'b0;
    new_status = sv_status;
    if (kind == KIND_START) begin
      sv_point = flow_cfg.initial_checkpoint;
      sv_seen = 1'b0;
      sv_passes = '0;
      sv_fails = '0;
      sv_status = ST_OK;
      new_status = ST_OK;
    end else if (kind == KIND_STOP) begin
      new_status = ST_DEACT;
    end else if (kind == KIND_REPORT && sv_status != ST_DEACT) begin
      res.report_handled = 1'b1;
      if (!sv_seen) begin
        ok = (cp == flow_cfg.initial_checkpoint);
        sv_seen = 1'b1;
      end else if (flow_cfg.allow_reset && cp == flow_cfg.initial_checkpoint) begin
        ok = 1'b1;
      end else begin
        ok = flow_cfg.adjacency_bits[{sv_point, cp}];
      end
      sv_point = cp;
      if (ok) begin
        if (sv_passes != '1) sv_passes = sv_passes + 1'b1;
        sv_fails = '0;
        if (sv_passes >= flow_cfg.pass_threshold) new_status = ST_OK;
      end else begin
        if (sv_fails != '1) sv_fails = sv_fails + 1'b1;
        sv_passes = '0;
        new_status = (sv_fails >= flow_cfg.fail_threshold) ? ST_EXPIRED : ST_FAILED;
      end
      res.report_passed = ok;
    end
    res.status_changed = (new_status != sv_status);
    sv_status = new_status;
    res.status = sv_status;
    return res;
  endfunction

  function automatic cfs_cfg_t make_cfg(input logic [ADJ_W-1:0] adj,
                                        input logic [PT_W-1:0] init_pt,
                                        input logic allow,
                                        input logic [CNT_W-1:0] pass_thr,
                                        input logic [CNT_W-1:0] fail_thr);
    cfs_cfg_t c;
    c.adjacency_bits = adj;
    c.initial_checkpoint = init_pt;
    c.allow_reset = allow;
    c.pass_threshold = pass_thr;
    c.fail_threshold = fail_thr;
    return c;
  endfunction

  // reset, also clears the shadow state
  task automatic apply_reset();
    rst_n <= 1'b0;
    flow_cfg = make_cfg('0, '0, 1'b0, 16'd1, 16'd1);
    sv_point = '0;
    sv_seen = 1'b0;
    sv_passes = '0;
    sv_fails = '0;
    sv_status = ST_DEACT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // writes all registers, junk above each narrow field
  task automatic program_config(input cfs_cfg_t c);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom(), $urandom()};
    write_reg(REG_ADJACENCY, c.adjacency_bits);
    write_reg(REG_INITIAL, {junk[CFG_DATA_W-1:PT_W], c.initial_checkpoint});
    write_reg(REG_ALLOW_RESET, {junk[CFG_DATA_W-1:1], c.allow_reset});
    write_reg(REG_PASS_THR, {junk[CFG_DATA_W-1:CNT_W], c.pass_threshold});
    write_reg(REG_FAIL_THR, {~junk[CFG_DATA_W-1:CNT_W], c.fail_threshold});
    cfg_we <= 1'b0;
    flow_cfg = c;
  endtask

  // offer one event word, predict it once accepted
  task automatic send_event(input logic [1:0] kind, input logic [PT_W-1:0] cp);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_checkpoint <= cp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back(supervise_event(kind, cp));
  endtask

  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // mostly a legal successor of the current checkpoint
  function automatic logic [PT_W-1:0] next_point();
    logic [7:0] row;
    logic [PT_W-1:0] p;
    row = flow_cfg.adjacency_bits[sv_point*8 +: 8];
    if (!sv_seen || row == 8'd0 ||
        (flow_cfg.allow_reset && $urandom_range(0, 5) == 0)) begin
      return flow_cfg.initial_checkpoint;
    end
    do p = PT_W'($urandom_range(0, 7)); while (!row[p]);
    return p;
  endfunction

  task automatic next_event(output logic [1:0] kind, output logic [PT_W-1:0] cp);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    cp = PT_W'($urandom_range(0, 7));
    if (sv_status == ST_DEACT) begin
      kind = (roll < 80) ? KIND_START : ((roll < 92) ? KIND_REPORT : KIND_UNUSED);
    end else if (roll < 4) begin
      kind = KIND_STOP;
    end else if (roll < 7) begin
      kind = KIND_START;
    end else if (roll < 9) begin
      kind = KIND_UNUSED;
    end else if (roll < 22) begin
      kind = KIND_REPORT;
    end else begin
      kind = KIND_REPORT;
      cp = next_point();
    end
  endtask

  function automatic logic [CNT_W-1:0] random_threshold();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '1;
    if (roll == 1) return CNT_W'($urandom_range(0, 65535));
    return CNT_W'($urandom_range(0, 4));
  endfunction

  function automatic cfs_cfg_t random_config(input int phase);
    logic [ADJ_W-1:0] adj;
    adj = {$urandom(), $urandom()};
    if (phase == 0) return make_cfg('1, PT_W'($urandom_range(0, 7)), 1'b1, '0, '0);
    if (phase == 1) return make_cfg('0, PT_W'($urandom_range(0, 7)), 1'b0, '1, '1);
    if (phase % 2 == 0) adj = adj & {$urandom(), $urandom()} & {$urandom(), $urandom()};
    return make_cfg(adj, PT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    random_threshold(), random_threshold());
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    cfs_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        flag_error("result word with no event pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (out_status !== want.status)
          flag_error($sformatf("status got %0d want %0d", out_status, want.status));
        if (out_status_changed !== want.status_changed)
          flag_error($sformatf("status_changed got %0b want %0b",
                               out_status_changed, want.status_changed));
        if (out_report_passed !== want.report_passed)
          flag_error($sformatf("report_passed got %0b want %0b",
                               out_report_passed, want.report_passed));
        if (out_report_handled !== want.report_handled)
          flag_error($sformatf("report_handled got %0b want %0b",
                               out_report_handled, want.report_handled));
      end
    end
  end

  // receiver stalls: random bursts, or one long hold on request
  initial begin : result_backpressure
    int len;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
        hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // reset settings: ignored reports, unused kind, first report, stops
  task automatic test_reset_defaults();
    send_event(KIND_REPORT, 3'd7);
    send_event(KIND_REPORT, 3'd0);
    send_event(KIND_UNUSED, 3'd5);
    send_event(KIND_START, 3'd2);
    send_event(KIND_REPORT, 3'd0);
    send_event(KIND_REPORT, 3'd0);
    send_event(KIND_UNUSED, 3'd2);
    send_event(KIND_STOP, 3'd1);
    send_event(KIND_STOP, 3'd6);
    wait_for_verdicts();
  endtask

  // full bitmap, top checkpoint, reset allowed, zero pass and max fail threshold
  task automatic test_config_extremes();
    program_config(make_cfg('1, 3'd7, 1'b1, '0, '1));
    send_event(KIND_START, 3'd0);
    send_event(KIND_REPORT, 3'd6);
    send_event(KIND_REPORT, 3'd7);
    send_event(KIND_REPORT, 3'd3);
    send_event(KIND_REPORT, 3'd7);
    send_event(KIND_START, 3'd4);
    send_event(KIND_STOP, 3'd7);
    wait_for_verdicts();
  endtask

  // empty bitmap, zero fail threshold, max pass threshold
  task automatic test_zero_fail_threshold();
    program_config(make_cfg('0, 3'd0, 1'b0, '1, '0));
    send_event(KIND_START, 3'd0);
    send_event(KIND_REPORT, 3'd0);
    send_event(KIND_REPORT, 3'd1);
    send_event(KIND_REPORT, 3'd0);
    send_event(KIND_STOP, 3'd0);
    send_event(KIND_REPORT, 3'd4);
    wait_for_verdicts();
  endtask

  // long fail and pass runs below the maximum thresholds
  task automatic test_long_runs();
    idle_on = 1'b0;
    program_config(make_cfg(64'h0101, 3'd0, 1'b0, '1, '1));
    send_event(KIND_START, 3'd0);
    send_event(KIND_REPORT, 3'd0);
    repeat (40) send_event(KIND_REPORT, 3'd1);
    repeat (41) send_event(KIND_REPORT, 3'd0);
    wait_for_verdicts();
    idle_on = 1'b1;
  endtask

  // long receiver hold while words keep coming
  task automatic test_backpressure();
    logic [1:0] kind;
    logic [PT_W-1:0] cp;
    idle_on = 1'b0;
    program_config(random_config(3));
    hold_request = 1'b1;
    wait (hold_active);
    send_event(KIND_START, 3'd0);
    repeat (40) begin
      next_event(kind, cp);
      send_event(kind, cp);
    end
    wait_for_verdicts();
    idle_on = 1'b1;
  endtask

  // random flows over several settings, last phase without idling
  task automatic test_random_flows();
    logic [1:0] kind;
    logic [PT_W-1:0] cp;
    int counted;
    for (int phase = 0; phase < 8; phase++) begin
      program_config(random_config(phase));
      idle_on = (phase < 7);
      counted = 0;
      while (counted < 80) begin
        next_event(kind, cp);
        if (!(kind == KIND_UNUSED || (kind == KIND_REPORT && sv_status == ST_DEACT)))
          counted++;
        send_event(kind, cp);
      end
      wait_for_verdicts();
    end
  endtask

  initial begin
    apply_reset();
    test_reset_defaults();
    test_config_extremes();
    test_zero_fail_threshold();
    test_long_runs();
    test_backpressure();
    test_random_flows();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
